// ===== hdl/ers_pkg.sv =====
// Shared types and constants for the elevator request scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ers_pkg;

	localparam int NUM_FLOORS_DEF   = 64;
	localparam int PENDING_BITS_DEF = 4;

	localparam int FLOOR_W = 6;
	localparam int LOAD_W  = 16;
	localparam int ACT_W   = 3;
	localparam int MOVE_W  = 2;
	localparam int IDX_W   = 2;
	// shared adder: 16-bit load plus a carry bit
	localparam int ALU_W   = LOAD_W + 1;

	localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PROCESS = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SECURE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_EMERG   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_ENTER   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_EXIT    = 3'd6;

	localparam logic [MOVE_W-1:0] MOVE_IDLE = 2'd0;
	localparam logic [MOVE_W-1:0] MOVE_UP   = 2'd1;
	localparam logic [MOVE_W-1:0] MOVE_DOWN = 2'd2;

	localparam logic [IDX_W-1:0] REG_BOTTOM = 2'd0;
	localparam logic [IDX_W-1:0] REG_TOP    = 2'd1;
	localparam logic [IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [FLOOR_W-1:0] BOTTOM_RST = 6'd0;
	localparam logic [FLOOR_W-1:0] TOP_RST    = 6'd63;
	localparam logic [LOAD_W-1:0]  LIMIT_RST  = 16'd1000;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [FLOOR_W-1:0] floor;
		logic               secure_value;
		logic [LOAD_W-1:0]  load_amount;
	} ers_in_t;

	typedef struct packed {
		logic               accepted;
		logic [FLOOR_W-1:0] current_floor;
		logic [MOVE_W-1:0]  move_state;
		logic               emergency_active;
		logic [LOAD_W-1:0]  car_load;
	} ers_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PUSH_WR,
		ST_LOAD_CHK,
		ST_SCAN_UP,
		ST_SCAN_DN,
		ST_SERVE
	} ers_state_t;

endpackage
`default_nettype wire

// ===== hdl/ers_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ers_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/elevator_request_scheduler_core.sv =====
// Top level of the single-car elevator request scheduler.
// A word is taken when start is high and busy is low; its result appears for one cycle
// with done high, one cycle after the work finishes, and must be taken then.
// Push passes through EXEC and, for a floor in range, PUSH_WR; set secure, emergency,
// clear and exit finish in EXEC, and enter passes through EXEC and LOAD_CHK.
// A process step walks the up count RAM from floor 0 upward, one floor per cycle,
// until it finds an up request, and otherwise walks the down count RAM from the top
// floor downward; a process step during an emergency and an unused action code
// finish in EXEC. Stored counts and secure flags are qualified by per-floor valid
// bits, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module elevator_request_scheduler_core #(
	parameter int NUM_FLOORS   = ers_pkg::NUM_FLOORS_DEF,
	parameter int PENDING_BITS = ers_pkg::PENDING_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire ers_pkg::ers_in_t            cmd,
	output logic                             done,
	output ers_pkg::ers_out_t                result,
	input  wire logic                        wr_en,
	input  wire logic [ers_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [ers_pkg::LOAD_W-1:0]  wr_data
);

	import ers_pkg::*;

	localparam int FLW = $clog2(NUM_FLOORS);
	localparam logic [FLW-1:0] LAST_FLOOR = FLW'(NUM_FLOORS - 1);
	localparam logic [PENDING_BITS-1:0] PMAX = '1;

	ers_state_t state_q, state_d;

	ers_in_t item_q;
	logic [FLOOR_W-1:0] bottom_q, top_q, car_floor_q;
	logic [LOAD_W-1:0]  limit_q, load_q;
	logic [MOVE_W-1:0]  motion_q;
	logic               emerg_q, ok_q, done_q;
	logic [ALU_W-1:0]   sum_q;
	logic               push_up_q;
	logic [FLW-1:0]     scan_cnt_q;
	logic               iss_q;
	logic               ev_vld_s1;
	logic [FLW-1:0]     rd_idx_s1;
	logic [FLW-1:0]     hit_idx_q;
	logic [PENDING_BITS-1:0] hit_cnt_q;
	logic               hit_up_q;
	logic [NUM_FLOORS-1:0] up_vld_q, dn_vld_q, sec_vld_q;

	// RAM ports
	logic [FLW-1:0]          rd_addr, wr_addr;
	logic [PENDING_BITS-1:0] cnt_wdata, up_rdata, dn_rdata;
	logic                    up_we, dn_we, sec_we, sec_rdata;

	// shared adder / subtractor
	logic [ALU_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [ALU_W:0]   alu_res;

	logic                    acc, in_rng, issue, fin;
	logic [FLW-1:0]          item_idx;
	logic [PENDING_BITS-1:0] up_cnt, dn_cnt, cnt_sel;
	logic                    sec_now, up_hit, dn_hit, ev_last_up, ev_last_dn;

	ers_ram #(.WIDTH(PENDING_BITS), .DEPTH(NUM_FLOORS)) u_up_ram (
		.clk(clk), .we(up_we), .waddr(wr_addr), .wdata(cnt_wdata),
		.raddr(rd_addr), .rdata(up_rdata)
	);

	ers_ram #(.WIDTH(PENDING_BITS), .DEPTH(NUM_FLOORS)) u_dn_ram (
		.clk(clk), .we(dn_we), .waddr(wr_addr), .wdata(cnt_wdata),
		.raddr(rd_addr), .rdata(dn_rdata)
	);

	ers_ram #(.WIDTH(1), .DEPTH(NUM_FLOORS)) u_sec_ram (
		.clk(clk), .we(sec_we), .waddr(wr_addr), .wdata(item_q.secure_value),
		.raddr(rd_addr), .rdata(sec_rdata)
	);

	assign acc      = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign item_idx = FLW'(item_q.floor);
	assign in_rng   = (item_q.floor >= bottom_q) && (item_q.floor <= top_q) &&
	                  (32'(item_q.floor) < 32'(NUM_FLOORS));

	assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                         : ({1'b0, alu_a} + {1'b0, alu_b});

	// RAM output belongs to the floor addressed in the previous cycle
	assign up_cnt  = up_vld_q[rd_idx_s1] ? up_rdata : '0;
	assign dn_cnt  = dn_vld_q[rd_idx_s1] ? dn_rdata : '0;
	assign sec_now = sec_vld_q[rd_idx_s1] && sec_rdata;
	assign cnt_sel = push_up_q ? up_cnt : dn_cnt;

	assign up_hit     = ev_vld_s1 && (up_cnt != '0) && !sec_now;
	assign dn_hit     = ev_vld_s1 && (dn_cnt != '0) && !sec_now;
	assign ev_last_up = ev_vld_s1 && (rd_idx_s1 == LAST_FLOOR);
	assign ev_last_dn = ev_vld_s1 && (rd_idx_s1 == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (item_q.action)
					ACT_PUSH:    state_d = in_rng ? ST_PUSH_WR : ST_IDLE;
					ACT_PROCESS: state_d = emerg_q ? ST_IDLE : ST_SCAN_UP;
					ACT_ENTER:   state_d = ST_LOAD_CHK;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_PUSH_WR:  state_d = ST_IDLE;
			ST_LOAD_CHK: state_d = ST_IDLE;
			ST_SCAN_UP: begin
				if (up_hit) state_d = ST_SERVE;
				else if (ev_last_up) state_d = ST_SCAN_DN;
			end
			ST_SCAN_DN: begin
				if (dn_hit) state_d = ST_SERVE;
				else if (ev_last_dn) state_d = ST_IDLE;
			end
			ST_SERVE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr   = '0;
		wr_addr   = item_idx;
		cnt_wdata = '0;
		up_we     = 1'b0;
		dn_we     = 1'b0;
		sec_we    = 1'b0;
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b0;
		issue     = 1'b0;
		case (state_q)
			ST_EXEC: begin
				rd_addr = item_idx;
				sec_we  = (item_q.action == ACT_SECURE) && in_rng;
				alu_a   = ALU_W'(load_q);
				alu_b   = ALU_W'(item_q.load_amount);
				alu_sub = (item_q.action == ACT_EXIT);
			end
			ST_PUSH_WR: begin
				wr_addr   = rd_idx_s1;
				alu_a     = ALU_W'(cnt_sel);
				alu_b     = ALU_W'(1);
				cnt_wdata = (cnt_sel == PMAX) ? cnt_sel : alu_res[PENDING_BITS-1:0];
				up_we     = push_up_q;
				dn_we     = !push_up_q;
			end
			ST_LOAD_CHK: begin
				alu_a   = ALU_W'(limit_q);
				alu_b   = sum_q;
				alu_sub = 1'b1;
			end
			ST_SCAN_UP, ST_SCAN_DN: begin
				rd_addr = scan_cnt_q;
				issue   = iss_q;
			end
			ST_SERVE: begin
				wr_addr   = hit_idx_q;
				alu_a     = ALU_W'(hit_cnt_q);
				alu_b     = ALU_W'(1);
				alu_sub   = 1'b1;
				cnt_wdata = alu_res[PENDING_BITS-1:0];
				up_we     = hit_up_q;
				dn_we     = !hit_up_q;
			end
			default: ;
		endcase
	end

	assign fin = (state_q != ST_IDLE) && (state_d == ST_IDLE);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bottom_q    <= BOTTOM_RST;
			top_q       <= TOP_RST;
			limit_q     <= LIMIT_RST;
			car_floor_q <= BOTTOM_RST;
			motion_q    <= MOVE_IDLE;
			emerg_q     <= 1'b0;
			load_q      <= '0;
			ok_q        <= 1'b0;
			done_q      <= 1'b0;
			scan_cnt_q  <= '0;
			iss_q       <= 1'b0;
			ev_vld_s1   <= 1'b0;
			up_vld_q    <= '0;
			dn_vld_q    <= '0;
			sec_vld_q   <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= fin;
			ev_vld_s1 <= issue && (state_d == state_q);

			if (wr_en) begin
				case (wr_index)
					REG_BOTTOM: bottom_q <= wr_data[FLOOR_W-1:0];
					REG_TOP:    top_q    <= wr_data[FLOOR_W-1:0];
					REG_LIMIT:  limit_q  <= wr_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_EXEC: begin
					case (item_q.action)
						ACT_PUSH: ok_q <= 1'b0;
						ACT_PROCESS: begin
							ok_q       <= 1'b0;
							scan_cnt_q <= '0;
							iss_q      <= !emerg_q;
						end
						ACT_SECURE: begin
							ok_q <= in_rng;
							if (in_rng) sec_vld_q[item_idx] <= 1'b1;
						end
						ACT_EMERG: begin
							emerg_q <= 1'b1;
							ok_q    <= 1'b1;
						end
						ACT_CLEAR: begin
							emerg_q <= 1'b0;
							ok_q    <= 1'b1;
						end
						ACT_EXIT: begin
							// borrow means more leaving than aboard
							ok_q <= !alu_res[ALU_W];
							if (!alu_res[ALU_W]) load_q <= alu_res[LOAD_W-1:0];
						end
						default: ok_q <= 1'b0;
					endcase
				end
				ST_PUSH_WR: begin
					ok_q <= 1'b1;
					if (push_up_q) up_vld_q[rd_idx_s1] <= 1'b1;
					else dn_vld_q[rd_idx_s1] <= 1'b1;
				end
				ST_LOAD_CHK: begin
					ok_q <= !alu_res[ALU_W];
					if (!alu_res[ALU_W]) load_q <= sum_q[LOAD_W-1:0];
				end
				ST_SCAN_UP: begin
					if (issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
						if (scan_cnt_q == LAST_FLOOR) iss_q <= 1'b0;
					end
					if (up_hit) begin
						iss_q <= 1'b0;
					end else if (ev_last_up) begin
						scan_cnt_q <= LAST_FLOOR;
						iss_q      <= 1'b1;
					end
				end
				ST_SCAN_DN: begin
					if (issue) begin
						scan_cnt_q <= scan_cnt_q - 1'b1;
						if (scan_cnt_q == '0) iss_q <= 1'b0;
					end
					if (dn_hit) begin
						iss_q <= 1'b0;
					end else if (ev_last_dn) begin
						motion_q <= MOVE_IDLE;
						ok_q     <= 1'b0;
					end
				end
				ST_SERVE: begin
					ok_q        <= 1'b1;
					car_floor_q <= FLOOR_W'(hit_idx_q);
					motion_q    <= hit_up_q ? MOVE_UP : MOVE_DOWN;
					// drop the secured requests skipped on the way
					for (int j = 0; j < NUM_FLOORS; j++) begin
						if (hit_up_q && (FLW'(j) < hit_idx_q)) up_vld_q[j] <= 1'b0;
						if (!hit_up_q && (FLW'(j) > hit_idx_q)) dn_vld_q[j] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) item_q <= cmd;
		rd_idx_s1 <= rd_addr;
		if (state_q == ST_EXEC) begin
			sum_q     <= alu_res[ALU_W-1:0];
			push_up_q <= (item_q.floor > car_floor_q);
		end
		if ((state_q == ST_SCAN_UP) && up_hit) begin
			hit_idx_q <= rd_idx_s1;
			hit_cnt_q <= up_cnt;
			hit_up_q  <= 1'b1;
		end
		if ((state_q == ST_SCAN_DN) && dn_hit) begin
			hit_idx_q <= rd_idx_s1;
			hit_cnt_q <= dn_cnt;
			hit_up_q  <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = '{
		accepted:         ok_q,
		current_floor:    car_floor_q,
		move_state:       motion_q,
		emergency_active: emerg_q,
		car_load:         load_q
	};

endmodule
`default_nettype wire

// ===== hdl/ers_chk.sv =====
// Port-level checks for the elevator request scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ers_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire ers_pkg::ers_out_t result
);

	import ers_pkg::*;

	// a taken word keeps the block busy on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a word was taken");

	// the result strobe only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// load and floor change only together with a result
	a_load_moves_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(result.car_load) || !$stable(result.current_floor)) |-> done)
		else $error("car load or floor changed without a result");

	a_move_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.move_state == MOVE_IDLE || result.move_state == MOVE_UP ||
		          result.move_state == MOVE_DOWN))
		else $error("bad move state code");

endmodule

bind elevator_request_scheduler_core ers_chk u_ers_chk (.*);
`default_nettype wire
